### rtl/core/rgbcc_pkg.sv
package rgbcc_pkg;

	localparam int FRAC_BITS   = 12;
	localparam int ONE         = 1 << FRAC_BITS;
	localparam int IN_W        = 16;
	localparam int PIX_W       = FRAC_BITS + 1;
	localparam int TABLE_DEPTH = 4096;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
	localparam int GAMMA_SHIFT = IN_W - TABLE_AW;
	localparam int DIV_STEPS   = FRAC_BITS + 1;
	localparam int CFG_W       = 16;

	// rec.709 luma weights, sum to ONE
	localparam int W_RED   = 871;
	localparam int W_GREEN = 2929;
	localparam int W_BLUE  = 296;

	typedef enum logic [2:0] {
		REG_GAMMA_ENABLE    = 3'd0,
		REG_TINT_RED        = 3'd1,
		REG_TINT_GREEN      = 3'd2,
		REG_TINT_BLUE       = 3'd3,
		REG_SATURATION_GAIN = 3'd4,
		REG_BRIGHTNESS_GAIN = 3'd5,
		REG_COLOR_ONLY_MODE = 3'd6,
		REG_BLACK_THRESHOLD = 3'd7
	} reg_idx_t;

	localparam logic ACT_SAMPLE      = 1'b0;
	localparam logic ACT_TABLE_WRITE = 1'b1;

	typedef logic [2:0][PIX_W-1:0] rgb_t;

endpackage

### rtl/core/rgb_color_correction.sv
// rgb color correction: one linear rgb word (q4.12 per channel) in, one corrected word
// (0..4096) out. gamma lookup through a loadable 4096-entry table (index = channel >> 4),
// tint gains, saturation around rec.709 luma, brightness, clamp, and an optional
// color-only normalization by the largest channel. one word is taken per clock while no
// stall holds the pipeline; a word passes a gamma table read stage, five arithmetic
// stages and a 13-stage divider for the normalization, one quotient bit each.
// table write words give no result. the table is held in three copies so the three
// channels read it in the same cycle; entries must be written before they are read.
// a stall on the result side holds the whole pipeline and raises sample_stall.
module rgb_color_correction import rgbcc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  logic                action,
	input  logic [IN_W-1:0]     red_in,
	input  logic [IN_W-1:0]     green_in,
	input  logic [IN_W-1:0]     blue_in,
	input  logic [TABLE_AW-1:0] table_address,
	input  logic [IN_W-1:0]     table_data,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [PIX_W-1:0]    red_out,
	output logic [PIX_W-1:0]    green_out,
	output logic [PIX_W-1:0]    blue_out,
	output logic                forced_black
);

	// configuration registers
	logic             gamma_en_q, mode_q;
	logic [12:0]      tint_q [3];
	logic [13:0]      sat_q;
	logic [15:0]      bright_q;
	logic [12:0]      thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_en_q <= 1'b0;
			tint_q[0]  <= 13'd4096;
			tint_q[1]  <= 13'd4096;
			tint_q[2]  <= 13'd4096;
			sat_q      <= 14'd4096;
			bright_q   <= 16'd4096;
			mode_q     <= 1'b0;
			thr_q      <= 13'd41;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_GAMMA_ENABLE:    gamma_en_q <= cfg_data[0];
				REG_TINT_RED:        tint_q[0]  <= cfg_data[12:0];
				REG_TINT_GREEN:      tint_q[1]  <= cfg_data[12:0];
				REG_TINT_BLUE:       tint_q[2]  <= cfg_data[12:0];
				REG_SATURATION_GAIN: sat_q      <= cfg_data[13:0];
				REG_BRIGHTNESS_GAIN: bright_q   <= cfg_data[15:0];
				REG_COLOR_ONLY_MODE: mode_q     <= cfg_data[0];
				REG_BLACK_THRESHOLD: thr_q      <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves together; held while a result waits on a stall
	logic en, accept;
	assign en           = !(result_valid && result_stall);
	assign sample_stall = !en;
	assign accept       = sample_valid && en;

	logic [IN_W-1:0] raw [3];
	assign raw[0] = red_in;
	assign raw[1] = green_in;
	assign raw[2] = blue_in;

	// gamma table copies, one read port per channel, shared write
	logic [IN_W-1:0] gamma_rd [3];
	for (genvar i = 0; i < 3; i++) begin : g_table
		rgbcc_ram #(.WIDTH(IN_W), .DEPTH(TABLE_DEPTH)) u_table (
			.clk   (clk),
			.we    (accept && action == ACT_TABLE_WRITE),
			.waddr (table_address),
			.wdata (table_data),
			.re    (en),
			.raddr (raw[i][GAMMA_SHIFT +: TABLE_AW]),
			.rdata (gamma_rd[i])
		);
	end

	localparam int DIV_LAST = DIV_STEPS - 1;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic valid_d_q [DIV_STEPS];

	logic [IN_W-1:0]          raw_s1 [3];
	logic [IN_W:0]            ch_s2  [3];
	logic [IN_W:0]            ch_s3  [3];
	logic [IN_W:0]            lum_s3;
	logic signed [IN_W+5:0]   v_s4   [3];
	rgb_t                     c_s5;
	rgb_t                     c_s6;
	logic [PIX_W-1:0]         mx_s6;
	logic                     black_s6, mode_s6;

	// lane arithmetic
	logic [IN_W-1:0]          gsel   [3];
	logic [IN_W+12:0]         tprod  [3];
	logic [IN_W+14:0]         lsum;
	logic signed [IN_W+1:0]   diff   [3];
	logic signed [IN_W+16:0]  sprod  [3];
	logic signed [IN_W+5:0]   vnx    [3];
	logic signed [IN_W+22:0]  bprod  [3];
	logic signed [IN_W+10:0]  bsh    [3];
	rgb_t                     clamp_nx;
	logic [PIX_W-1:0]         mx_nx;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			gsel[i]  = gamma_en_q ? gamma_rd[i] : raw_s1[i];
			tprod[i] = {13'd0, gsel[i]} * {16'd0, tint_q[i]};
			diff[i]  = $signed({1'b0, ch_s3[i]}) - $signed({1'b0, lum_s3});
			sprod[i] = $signed({{(IN_W+3){1'b0}}, sat_q}) * {{15{diff[i][IN_W+1]}}, diff[i]};
			vnx[i]   = $signed({5'd0, lum_s3}) + (IN_W+6)'(sprod[i] >>> FRAC_BITS);
			bprod[i] = {{17{v_s4[i][IN_W+5]}}, v_s4[i]}
				* $signed({{(IN_W+7){1'b0}}, bright_q});
			bsh[i]   = (IN_W+11)'(bprod[i] >>> FRAC_BITS);
			if (bsh[i] < 0) begin
				clamp_nx[i] = '0;
			end else if (bsh[i] > ONE) begin
				clamp_nx[i] = PIX_W'(ONE);
			end else begin
				clamp_nx[i] = bsh[i][PIX_W-1:0];
			end
		end
		lsum = (IN_W+15)'(W_RED) * {14'd0, ch_s2[0]}
			+ (IN_W+15)'(W_GREEN) * {14'd0, ch_s2[1]}
			+ (IN_W+15)'(W_BLUE) * {14'd0, ch_s2[2]};
		mx_nx = c_s5[0];
		if (c_s5[1] > mx_nx) mx_nx = c_s5[1];
		if (c_s5[2] > mx_nx) mx_nx = c_s5[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept && action == ACT_SAMPLE;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				raw_s1[i] <= raw[i];
				ch_s2[i]  <= tprod[i][FRAC_BITS +: IN_W+1];
				ch_s3[i]  <= ch_s2[i];
				v_s4[i]   <= vnx[i];
			end
			lum_s3   <= lsum[FRAC_BITS +: IN_W+1];
			c_s5     <= clamp_nx;
			c_s6     <= c_s5;
			mx_s6    <= mx_nx;
			mode_s6  <= mode_q;
			black_s6 <= mode_q && !(mx_nx > thr_q);
		end
	end

	// normalization divider and its side band
	rgb_t quo;
	rgbcc_div u_div (
		.clk (clk),
		.en  (en),
		.num (c_s6),
		.den (mx_s6),
		.quo (quo)
	);

	rgb_t c_d_q     [DIV_STEPS];
	logic mode_d_q  [DIV_STEPS];
	logic black_d_q [DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DIV_STEPS; j++) valid_d_q[j] <= 1'b0;
		end else if (en) begin
			valid_d_q[0] <= valid_s6;
			for (int j = 1; j < DIV_STEPS; j++) valid_d_q[j] <= valid_d_q[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_d_q[0]     <= c_s6;
			mode_d_q[0]  <= mode_s6;
			black_d_q[0] <= black_s6;
			for (int j = 1; j < DIV_STEPS; j++) begin
				c_d_q[j]     <= c_d_q[j-1];
				mode_d_q[j]  <= mode_d_q[j-1];
				black_d_q[j] <= black_d_q[j-1];
			end
		end
	end

	rgb_t res;
	always_comb begin
		if (!mode_d_q[DIV_LAST]) begin
			res = c_d_q[DIV_LAST];
		end else if (black_d_q[DIV_LAST]) begin
			res = '0;
		end else begin
			res = quo;
		end
	end

	assign result_valid = valid_d_q[DIV_LAST];
	assign red_out      = res[0];
	assign green_out    = res[1];
	assign blue_out     = res[2];
	assign forced_black = black_d_q[DIV_LAST];

	// forced black only comes out of color-only mode and always reads as zero
	a_black_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && forced_black |-> res == '0 && mode_d_q[DIV_LAST])
		else $error("forced black with nonzero color");

	// results never exceed full scale
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> res[0] <= PIX_W'(ONE) && res[1] <= PIX_W'(ONE)
			&& res[2] <= PIX_W'(ONE))
		else $error("result above full scale");

	// a table write word never turns into a result slot
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == ACT_TABLE_WRITE |=> !valid_s1)
		else $error("table write produced a result");

	// pipeline frozen while a result is stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(res))
		else $error("stalled result changed");

endmodule

### rtl/core/rgbcc_ram.sv
module rgbcc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/rgbcc_div.sv
module rgbcc_div import rgbcc_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  rgb_t             num,
	input  logic [PIX_W-1:0] den,
	output rgb_t             quo
);

	// restoring division of num*ONE by den, one quotient bit per stage, num <= den
	rgb_t             rem_q [DIV_STEPS];
	rgb_t             quo_q [DIV_STEPS];
	logic [PIX_W-1:0] den_q [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		rgb_t             rem_prev, quo_prev, rem_nx, quo_nx;
		logic [PIX_W-1:0] den_prev;
		logic [PIX_W:0]   trial [3];

		if (j == 0) begin : g_first
			assign rem_prev = num;
			assign quo_prev = '0;
			assign den_prev = den;
		end else begin : g_next
			assign rem_prev = rem_q[j-1];
			assign quo_prev = quo_q[j-1];
			assign den_prev = den_q[j-1];
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				trial[i] = (j == 0) ? {1'b0, rem_prev[i]} : {rem_prev[i], 1'b0};
				if (trial[i] >= {1'b0, den_prev}) begin
					rem_nx[i] = PIX_W'(trial[i] - {1'b0, den_prev});
					quo_nx[i] = {quo_prev[i][PIX_W-2:0], 1'b1};
				end else begin
					rem_nx[i] = trial[i][PIX_W-1:0];
					quo_nx[i] = {quo_prev[i][PIX_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j] <= rem_nx;
				quo_q[j] <= quo_nx;
				den_q[j] <= den_prev;
			end
		end
	end

	assign quo = quo_q[DIV_STEPS-1];

endmodule

### tb/sv/testbench.sv
module testbench;
	import rgbcc_pkg::*;

	// pipeline depth of the block; the drain wait adds a margin on top
	localparam int PIPE_DEPTH = 19;
	localparam int RANDOM_WORDS = 1120;
	localparam int PHASE_WORDS = 140;
	// stride of the table entries loaded before gamma mode is used
	localparam int FILL_STRIDE = 8;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic sample_valid;
	logic sample_stall;
	logic action;
	logic [IN_W-1:0] red_in, green_in, blue_in;
	logic [TABLE_AW-1:0] table_address;
	logic [IN_W-1:0] table_data;
	logic result_valid;
	logic result_stall;
	logic [PIX_W-1:0] red_out, green_out, blue_out;
	logic forced_black;

	rgb_color_correction dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.action(action), .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.table_address(table_address), .table_data(table_data),
		.result_valid(result_valid), .result_stall(result_stall),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.forced_black(forced_black)
	);

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic black;
	} color_t;

	// one row of the directed table; check_fixed means the expected color is typed in
	typedef struct {
		logic act;
		logic [IN_W-1:0] r, g, b;
		logic [TABLE_AW-1:0] addr;
		logic [IN_W-1:0] data;
		logic check_fixed;
		color_t fixed;
	} stim_row_t;

	color_t corrected_q[$];

	// shadow copy of the register file and the gamma table
	logic gamma_on;
	logic [12:0] tint_gain [3];
	logic [13:0] sat_gain;
	logic [15:0] bright_gain;
	logic color_only;
	logic [12:0] black_level;
	logic [15:0] gamma_lut [TABLE_DEPTH];
	bit lut_written [TABLE_DEPTH];

	int errors = 0;
	int hold_cycles = 0;   // forced long receiver hold-off, counted down by the sink
	bit stim_done = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// generous fixed limit on the whole run
	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// floor divide by 4096 of a signed value; >>> on a signed 64-bit is floor
	function automatic longint fshift(input longint x);
		return x >>> FRAC_BITS;
	endfunction

	function automatic color_t correct_color(input logic [IN_W-1:0] r, g, b);
		longint ch [3];
		longint lum, v, mx;
		logic [IN_W-1:0] c;
		color_t res;
		for (int i = 0; i < 3; i++) begin
			c = (i == 0) ? r : (i == 1) ? g : b;
			if (gamma_on)
				c = gamma_lut[c[IN_W-1:GAMMA_SHIFT]];
			ch[i] = (longint'(c) * longint'(tint_gain[i])) >> FRAC_BITS;
		end
		lum = fshift(W_RED * ch[0] + W_GREEN * ch[1] + W_BLUE * ch[2]);
		for (int i = 0; i < 3; i++) begin
			v = lum + fshift(longint'(sat_gain) * (ch[i] - lum));
			v = fshift(v * longint'(bright_gain));
			ch[i] = (v < 0) ? 0 : (v > ONE) ? ONE : v;
		end
		res.black = 0;
		if (color_only) begin
			mx = ch[0];
			if (ch[1] > mx) mx = ch[1];
			if (ch[2] > mx) mx = ch[2];
			if (mx > black_level) begin
				for (int i = 0; i < 3; i++)
					ch[i] = (ch[i] * ONE) / mx;
			end else begin
				ch[0] = 0; ch[1] = 0; ch[2] = 0;
				res.black = 1;
			end
		end
		res.red = ch[0][PIX_W-1:0];
		res.green = ch[1][PIX_W-1:0];
		res.blue = ch[2][PIX_W-1:0];
		return res;
	endfunction

	task automatic write_reg(input reg_idx_t idx, input int value);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_GAMMA_ENABLE:    gamma_on = value[0];
			REG_TINT_RED:        tint_gain[0] = value[12:0];
			REG_TINT_GREEN:      tint_gain[1] = value[12:0];
			REG_TINT_BLUE:       tint_gain[2] = value[12:0];
			REG_SATURATION_GAIN: sat_gain = value[13:0];
			REG_BRIGHTNESS_GAIN: bright_gain = value[15:0];
			REG_COLOR_ONLY_MODE: color_only = value[0];
			REG_BLACK_THRESHOLD: black_level = value[12:0];
			default: ;
		endcase
	endtask

	// wait until every expected word has come back, then let the pipe empty
	task automatic drain;
		while (corrected_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	// offer one word and hold it until accepted; gap cycles go before it
	task automatic send_word(input logic act, input logic [IN_W-1:0] r, g, b,
			input logic [TABLE_AW-1:0] addr, input logic [IN_W-1:0] data,
			input int gap, input bit use_fixed, input color_t fixed);
		if (gap > 0) begin
			sample_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1;
		action <= act;
		red_in <= r; green_in <= g; blue_in <= b;
		table_address <= addr; table_data <= data;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		// accepted at this edge: update the prediction
		if (act == ACT_TABLE_WRITE) begin
			gamma_lut[addr] = data;
			lut_written[addr] = 1;
		end else begin
			corrected_q.push_back(use_fixed ? fixed : correct_color(r, g, b));
		end
	endtask

	function automatic int rand_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// with gamma on, only channels that land on loaded table entries
	function automatic logic [IN_W-1:0] rand_chan();
		logic [IN_W-1:0] c;
		do begin
			case ($urandom_range(0, 5))
				0: c = 16'h0000;
				1: c = 16'hFFFF;
				2: c = IN_W'($urandom_range(0, ONE));
				default: c = IN_W'($urandom());
			endcase
		end while (gamma_on && !lut_written[c[IN_W-1:GAMMA_SHIFT]]);
		return c;
	endfunction

	// result side: random stalls, and a long hold-off when hold_cycles is set
	initial begin
		color_t exp_c;
		result_stall = 1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				if (corrected_q.size() == 0) begin
					report_mismatch("unexpected word", red_out, -1);
				end else begin
					exp_c = corrected_q.pop_front();
					if (red_out !== exp_c.red) report_mismatch("red", red_out, exp_c.red);
					if (green_out !== exp_c.green)
						report_mismatch("green", green_out, exp_c.green);
					if (blue_out !== exp_c.blue) report_mismatch("blue", blue_out, exp_c.blue);
					if (forced_black !== exp_c.black)
						report_mismatch("forced_black", forced_black, exp_c.black);
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				result_stall <= 1;
			end else if (stim_done || $urandom_range(0, 99) < 70) begin
				result_stall <= 0;
			end else begin
				result_stall <= 1;
			end
		end
	end

	stim_row_t rows [$];

	function automatic stim_row_t mk(input logic act, input int r, g, b, addr, data,
			input bit fx, input color_t want);
		stim_row_t s;
		s.act = act; s.r = IN_W'(r); s.g = IN_W'(g); s.b = IN_W'(b);
		s.addr = TABLE_AW'(addr); s.data = IN_W'(data);
		s.check_fixed = fx; s.fixed = want;
		return s;
	endfunction

	initial begin
		color_t none;
		color_t white;
		color_t zero_c;
		color_t blk;
		int n;
		none = '0;
		zero_c = '0;
		white = '{red: PIX_W'(ONE), green: PIX_W'(ONE), blue: PIX_W'(ONE), black: 1'b0};
		blk = '{red: '0, green: '0, blue: '0, black: 1'b1};

		arst_n = 0;
		cfg_we = 0; cfg_index = REG_GAMMA_ENABLE; cfg_data = 0;
		sample_valid = 0; action = ACT_SAMPLE;
		red_in = 0; green_in = 0; blue_in = 0; table_address = 0; table_data = 0;
		gamma_on = 0;
		tint_gain[0] = 13'(ONE); tint_gain[1] = 13'(ONE); tint_gain[2] = 13'(ONE);
		sat_gain = 14'(ONE); bright_gain = 16'(ONE); color_only = 0; black_level = 13'd41;
		foreach (lut_written[i]) lut_written[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: reset gains are neutral, so black and clamped white are obvious
		rows.push_back(mk(ACT_SAMPLE, 0, 0, 0, 0, 0, 1, zero_c));
		rows.push_back(mk(ACT_SAMPLE, ONE, ONE, ONE, 0, 0, 1, white));
		rows.push_back(mk(ACT_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 1, white));
		rows.push_back(mk(ACT_SAMPLE, 16'hFFFF, 0, 0, 0, 0, 0, none));
		rows.push_back(mk(ACT_SAMPLE, 0, 16'hFFFF, 0, 0, 0, 0, none));
		rows.push_back(mk(ACT_SAMPLE, 0, 0, 16'hFFFF, 0, 0, 0, none));
		rows.push_back(mk(ACT_SAMPLE, 1234, 2048, 77, 0, 0, 0, none));
		// table writes at both address extremes give no word
		rows.push_back(mk(ACT_TABLE_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 0, none));
		rows.push_back(mk(ACT_TABLE_WRITE, 0, 0, 0, 4095, 0, 0, none));
		foreach (rows[i])
			send_word(rows[i].act, rows[i].r, rows[i].g, rows[i].b, rows[i].addr,
				rows[i].data, rand_gap(), rows[i].check_fixed, rows[i].fixed);

		// load every eighth entry and the last one; gamma inputs only hit those
		for (int a = 0; a < TABLE_DEPTH; a++)
			if (a % FILL_STRIDE == 0 || a == TABLE_DEPTH - 1)
				send_word(ACT_TABLE_WRITE, IN_W'($urandom()), IN_W'($urandom()),
					IN_W'($urandom()), TABLE_AW'(a),
					(a == 0) ? 16'h0000 : (a == 4095) ? 16'hFFFF : 16'($urandom()),
					($urandom_range(0, 9) == 0) ? 1 : 0, 0, none);
		sample_valid <= 0;
		drain();

		// color-only with zero threshold: a black input forces black
		write_reg(REG_COLOR_ONLY_MODE, 1);
		write_reg(REG_BLACK_THRESHOLD, 0);
		rows.delete();
		rows.push_back(mk(ACT_SAMPLE, 0, 0, 0, 0, 0, 1, blk));
		rows.push_back(mk(ACT_SAMPLE, ONE, ONE, ONE, 0, 0, 1, white));
		rows.push_back(mk(ACT_SAMPLE, 100, 50, 3000, 0, 0, 0, none));
		// zero tint on every channel makes everything dark
		foreach (rows[i])
			send_word(rows[i].act, rows[i].r, rows[i].g, rows[i].b, rows[i].addr,
				rows[i].data, 0, rows[i].check_fixed, rows[i].fixed);
		sample_valid <= 0;
		drain();
		write_reg(REG_TINT_RED, 0);
		write_reg(REG_TINT_GREEN, 0);
		write_reg(REG_TINT_BLUE, 0);
		write_reg(REG_BLACK_THRESHOLD, ONE);
		send_word(ACT_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 1, blk);
		sample_valid <= 0;
		drain();
		write_reg(REG_GAMMA_ENABLE, 1);
		send_word(ACT_SAMPLE, 16'hFFFF, 1, 16'h8000, 0, 0, 0, 0, none);
		sample_valid <= 0;
		drain();

		// random phases, each with a fresh setting; extremes appear often
		n = 0;
		for (int ph = 0; n < RANDOM_WORDS; ph++) begin
			write_reg(REG_GAMMA_ENABLE, $urandom_range(0, 1));
			write_reg(REG_TINT_RED, ($urandom_range(0, 3) == 0) ? ONE : $urandom_range(0, ONE));
			write_reg(REG_TINT_GREEN, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, ONE));
			write_reg(REG_TINT_BLUE, $urandom_range(0, ONE));
			write_reg(REG_SATURATION_GAIN, (ph % 4 == 0) ? 16383 : (ph % 4 == 1) ? 0 :
				$urandom_range(0, 16383));
			write_reg(REG_BRIGHTNESS_GAIN, (ph % 5 == 0) ? 65535 : (ph % 5 == 1) ? 0 :
				$urandom_range(0, 12000));
			write_reg(REG_COLOR_ONLY_MODE, $urandom_range(0, 1));
			write_reg(REG_BLACK_THRESHOLD, (ph % 3 == 0) ? ONE : $urandom_range(0, 300));
			// once the receiver holds off long so the pipe fills and stalls the input
			if (ph == 1) hold_cycles = 200;
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if ($urandom_range(0, 19) == 0)
					send_word(ACT_TABLE_WRITE, IN_W'($urandom()), IN_W'($urandom()),
						IN_W'($urandom()), TABLE_AW'($urandom()), IN_W'($urandom()),
						rand_gap(), 0, none);
				else
					send_word(ACT_SAMPLE, rand_chan(), rand_chan(), rand_chan(),
						TABLE_AW'($urandom()), IN_W'($urandom()),
						(ph % 4 == 2) ? 0 : rand_gap(), 0, none);
				n++;
			end
			sample_valid <= 0;
			drain();
		end

		stim_done = 1;
		n = 0;
		while (corrected_q.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (errors == 0 && corrected_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
